FILE: hdl/srb_pkg.sv
// Shared types, codes and defaults for the split-flap reel bank stepper.
package srb_pkg;

  // built-in defaults for the top-level parameters
  localparam int unsigned DEF_REEL_FLAPS        = 128;
  localparam int unsigned DEF_MAX_MODULES       = 64;
  localparam int unsigned DEF_DEFAULT_CAP       = 10;
  localparam int unsigned DEF_DEFAULT_PERIOD_MS = 60;

  // fixed field widths
  localparam int unsigned POS_W   = 7;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 16;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  // output word bit positions
  localparam int unsigned OD_REPAINT_BIT = 15;
  localparam int unsigned OD_MOVED_BIT   = 16;

  // opcodes
  localparam logic [1:0] OP_SHOW = 2'd0;
  localparam logic [1:0] OP_HOME = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_FLAP_CAP    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FLAP_PERIOD = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ACTIVE_MODS = 2'd2;

  // one stored reel entry
  typedef struct packed {
    logic [TIME_W-1:0] next_t;
    logic              phase;
    logic [POS_W-1:0]  tgt;
    logic              tgt_vld;
    logic [POS_W-1:0]  pos;
  } reel_t;

  // per-item control handed to the update logic
  typedef struct packed {
    logic              is_tick;
    logic [IDX_W-1:0]  want;
    logic [TIME_W-1:0] now;
    logic [IDX_W-1:0]  cap;
    logic [HALF_W-1:0] half;
  } upd_ctl_t;

  // per-entry status from the update logic
  typedef struct packed {
    logic emit;
    logic arrived;
    logic repaint;
  } upd_sts_t;

  // one result word
  typedef struct packed {
    logic             last;
    logic             moved;
    logic             repaint;
    logic             arrived;
    logic             mid;
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  id;
  } res_t;

endpackage

FILE: hdl/split_flap_reel_bank_stepper.sv
// A tick or a broadcast set/home sweeps every active reel, an addressed set/home only its one
// reel; an unused code or an address with no such reel gives only a closing word.
// One item at a time: the next item is taken once the last word of the current one is loaded.
// Output stalls hold the sweep in place; a finished word waits in the output register.
// Reset: config to defaults (cap 0, period 0, 64 reels), every reel reads as homed at once.
module split_flap_reel_bank_stepper import srb_pkg::*; #(
  parameter int unsigned REEL_FLAPS        = DEF_REEL_FLAPS,
  parameter int unsigned MAX_MODULES       = DEF_MAX_MODULES,
  parameter int unsigned DEFAULT_CAP       = DEF_DEFAULT_CAP,
  parameter int unsigned DEFAULT_PERIOD_MS = DEF_DEFAULT_PERIOD_MS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_AW-1:0]      cfg_addr_i,
  input  logic [CFG_DW-1:0]      cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // broadcast, module_address[7:0], flap_index[7:0], now_ms[31:0], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // module_id[5:0], flap_position[6:0], mid_flip, arrived, repaint_request, any_moved, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int unsigned AW   = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam logic [6:0]  MaxN = 7'(MAX_MODULES);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FINAL = 3'b100
  } seq_state_e;

  seq_state_e state_q, state_d;

  logic [7:0]        cap_q, cap_d;
  logic [15:0]       period_q, period_d;
  logic [6:0]        active_q, active_d;

  logic              tick_q, tick_d;
  logic [IDX_W-1:0]  want_q, want_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic              rep_q, rep_d;
  logic [AW-1:0]     ra_q, ra_d, hi_q, hi_d;
  logic              issue_done_q, issue_done_d;
  logic              s1_vld_q, s1_vld_d;
  logic [AW-1:0]     s1_addr_q, s1_addr_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d;
  logic              out_vld_q, out_vld_d;
  res_t              out_q, out_d;

  logic [6:0]        n_act;
  logic [HALF_W-1:0] period_eff, half;
  upd_ctl_t          ctl;
  upd_sts_t          sts;
  reel_t             cur, nxt;
  res_t              new_res;
  logic              out_free, stall, issue;
  logic [1:0]        in_op;
  logic              in_bcast;
  logic [7:0]        in_addr;
  logic [7:0]        in_idx;

  assign in_op    = s_axis_tuser;
  assign in_bcast = s_axis_tdata[0];
  assign in_addr  = s_axis_tdata[8:1];
  assign in_idx   = s_axis_tdata[16:9];

  always_comb begin
    if (active_q == 7'd0) begin
      n_act = 7'd1;
    end else if (active_q > MaxN) begin
      n_act = MaxN;
    end else begin
      n_act = active_q;
    end
    period_eff  = (period_q == 16'd0) ? HALF_W'(DEFAULT_PERIOD_MS) : period_q;
    half        = period_eff >> 1;
    if (half == '0) begin
      half = HALF_W'(1);
    end
    ctl.is_tick = tick_q;
    ctl.want    = want_q;
    ctl.now     = now_q;
    ctl.cap     = (cap_q == 8'd0) ? 8'(DEFAULT_CAP) : cap_q;
    ctl.half    = half;
  end

  srb_state_mem #(
    .DEPTH (MAX_MODULES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (issue),
    .raddr_i (ra_q),
    .rdata_o (cur),
    .we_i    (s1_vld_q && !stall),
    .waddr_i (s1_addr_q),
    .wdata_i (nxt)
  );

  srb_reel_update #(
    .REEL_FLAPS (REEL_FLAPS)
  ) u_upd (
    .ctl_i (ctl),
    .cur_i (cur),
    .nxt_o (nxt),
    .sts_o (sts)
  );

  always_comb begin
    new_res         = '0;
    new_res.id      = ID_W'(s1_addr_q);
    new_res.pos     = nxt.pos;
    new_res.mid     = nxt.phase;
    new_res.arrived = sts.arrived;
    new_res.moved   = 1'b1;
  end

  assign out_free = !out_vld_q || m_axis_tready;
  // a second moving reel needs the output register to take the held word
  assign stall    = s1_vld_q && sts.emit && pend_vld_q && !out_free;
  assign issue    = (state_q == ST_SWEEP) && !issue_done_q && !stall;

  always_comb begin
    cap_d    = cap_q;
    period_d = period_q;
    active_d = active_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FLAP_CAP:    cap_d    = cfg_wdata_i[7:0];
        CFG_FLAP_PERIOD: period_d = cfg_wdata_i;
        CFG_ACTIVE_MODS: active_d = cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    want_d       = want_q;
    now_d        = now_q;
    rep_d        = rep_q;
    ra_d         = ra_q;
    hi_d         = hi_q;
    issue_done_d = issue_done_q;
    s1_vld_d     = 1'b0;
    s1_addr_d    = s1_addr_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_d        = out_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          tick_d       = (in_op == OP_TICK);
          want_d       = (in_op == OP_SHOW) ? in_idx : 8'd0;
          now_d        = s_axis_tdata[48:17];
          rep_d        = 1'b0;
          pend_vld_d   = 1'b0;
          issue_done_d = 1'b0;
          if ((in_op == OP_TICK) || ((in_op inside {OP_SHOW, OP_HOME}) && in_bcast)) begin
            ra_d    = '0;
            hi_d    = AW'(n_act - 7'd1);
            state_d = ST_SWEEP;
          end else if ((in_op inside {OP_SHOW, OP_HOME}) &&
                       ({1'b0, in_addr} < {2'b0, n_act})) begin
            ra_d    = AW'(in_addr);
            hi_d    = AW'(in_addr);
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_SWEEP: begin
        if (issue) begin
          ra_d      = ra_q + AW'(1);
          s1_addr_d = ra_q;
          if (ra_q == hi_q) begin
            issue_done_d = 1'b1;
          end
        end
        s1_vld_d = issue || (s1_vld_q && stall);
        if (s1_vld_q && !stall) begin
          if (sts.repaint) begin
            rep_d = 1'b1;
          end
          if (sts.emit) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d     = new_res;
          end
        end
        if (issue_done_q && !s1_vld_q) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
            pend_vld_d = 1'b0;
          end else begin
            out_d         = '0;
            out_d.repaint = rep_q;
            out_d.last    = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= '0;
      period_q     <= '0;
      active_q     <= 7'd64;
      issue_done_q <= 1'b0;
      s1_vld_q     <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      rep_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      period_q     <= period_d;
      active_q     <= active_d;
      issue_done_q <= issue_done_d;
      s1_vld_q     <= s1_vld_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
      rep_q        <= rep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q    <= tick_d;
    want_q    <= want_d;
    now_q     <= now_d;
    ra_q      <= ra_d;
    hi_q      <= hi_d;
    s1_addr_q <= s1_addr_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'b0, out_q.moved, out_q.repaint, out_q.arrived, out_q.mid,
                          out_q.pos, out_q.id};

endmodule

FILE: hdl/srb_state_mem.sv
// Reel state memory: one write port, one registered read port, per-entry valid flops.
module srb_state_mem import srb_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_MODULES,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output reel_t         rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  reel_t         wdata_i
);

  reel_t             mem_q [DEPTH];
  reel_t             rdata_q;
  logic [DEPTH-1:0]  vld_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // never-written entries read as the homed reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: hdl/srb_reel_update.sv
// Per-reel update: applies a set/home target or a half-flap tick step to one entry.
module srb_reel_update import srb_pkg::*; #(
  parameter int unsigned REEL_FLAPS = DEF_REEL_FLAPS
) (
  input  upd_ctl_t ctl_i,
  input  reel_t    cur_i,
  output reel_t    nxt_o,
  output upd_sts_t sts_o
);

  localparam logic [8:0] Flaps = 9'(REEL_FLAPS);

  logic [8:0]        want9, pos9, cap9, dist9, start9, inc9;
  logic [TIME_W-1:0] diff;
  logic              in_range, due;

  always_comb begin
    want9    = {1'b0, ctl_i.want};
    pos9     = {2'b0, cur_i.pos};
    cap9     = {1'b0, ctl_i.cap};
    in_range = want9 < Flaps;
    dist9    = (want9 >= pos9) ? (want9 - pos9) : (want9 + Flaps - pos9);
    // cap is below the reel size whenever this start is used
    start9   = (want9 >= cap9) ? (want9 - cap9) : (want9 + Flaps - cap9);
    inc9     = (pos9 + 9'd1 == Flaps) ? 9'd0 : (pos9 + 9'd1);
    diff     = ctl_i.now - cur_i.next_t;
    due      = cur_i.tgt_vld && !diff[TIME_W-1];

    nxt_o = cur_i;
    sts_o = '0;

    if (ctl_i.is_tick) begin
      if (due) begin
        sts_o.emit = 1'b1;
        if (!cur_i.phase) begin
          nxt_o.phase = 1'b1;
        end else begin
          nxt_o.pos   = POS_W'(inc9);
          nxt_o.phase = 1'b0;
          if (POS_W'(inc9) == cur_i.tgt) begin
            nxt_o.tgt_vld = 1'b0;
            sts_o.arrived = 1'b1;
          end
        end
        nxt_o.next_t = ctl_i.now + TIME_W'(ctl_i.half);
      end
    end else if (in_range) begin
      if (want9 == pos9) begin
        sts_o.repaint = cur_i.phase;
        nxt_o.tgt_vld = 1'b0;
        nxt_o.phase   = 1'b0;
      end else begin
        if (dist9 > cap9) begin
          nxt_o.pos = POS_W'(start9);
        end
        nxt_o.tgt_vld = 1'b1;
        nxt_o.tgt     = POS_W'(want9);
        nxt_o.phase   = 1'b0;
        nxt_o.next_t  = ctl_i.now;
      end
    end
  end

endmodule

FILE: hdl/srb_checker.sv
// Port-level checks for the reel bank stepper, bound to the top level.
module srb_checker import srb_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // only step words can be followed by more words of the same item
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OD_MOVED_BIT] |-> m_axis_tlast)
    else $error("non-step word without last");

  // step words never carry a repaint request
  a_step_norep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OD_MOVED_BIT] |-> !m_axis_tdata[OD_REPAINT_BIT])
    else $error("step word with repaint");

endmodule

bind split_flap_reel_bank_stepper srb_checker u_srb_checker (.*);
